@@ rtl/core/ttsc_pkg.sv @@
// shared constants, item types, divider request types and sequencer states of the tap tempo clock
`default_nettype none

package ttsc_pkg;

  localparam int unsigned STEPS_PER_BAR   = 16;
  localparam int unsigned TAPS_TO_AVERAGE = 4;

  // steps per quarter of the sequence
  localparam int unsigned BAR_LEN  = STEPS_PER_BAR / 4;
  localparam int unsigned STEP_W   = $clog2(STEPS_PER_BAR);
  localparam int unsigned POS_W    = (BAR_LEN > 1) ? $clog2(BAR_LEN) : 1;
  localparam int unsigned TC_W     = $clog2(TAPS_TO_AVERAGE + 1);
  localparam int unsigned IDX_W    = $clog2(TAPS_TO_AVERAGE);
  localparam bit          TAPS_POW2 = ((1 << IDX_W) == TAPS_TO_AVERAGE);
  localparam int unsigned SUM_W    = 16 + IDX_W;

  // shared divider
  localparam int unsigned DIV_W  = 36;
  localparam int unsigned DVS_W  = 16;
  localparam int unsigned ITER_W = $clog2(DIV_W + 1);

  localparam int unsigned BPM_NUM   = 60000;
  localparam int unsigned RESET_BPM = 120;

  // 960000 * 2^16 / STEPS_PER_BAR, divided by bpm gives the Q16 step period
  localparam logic [DIV_W-1:0] PER_NUM = DIV_W'((64'd960000 << 16) / STEPS_PER_BAR);
  localparam logic [DIV_W-1:0] RESET_Q =
    DIV_W'(((64'd960000 << 16) / STEPS_PER_BAR) / RESET_BPM);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXT_SYNC    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_BPM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_TIMEOUT = 2'd2;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        tap;
    logic        restart;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  step_index;
    logic [1:0]  bar_index;
    logic [15:0] tempo_bpm;
    logic        step_advanced;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
    logic [ITER_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TAP,
    ST_SUM,
    ST_AVG_DIV,
    ST_BPM,
    ST_BPM_DIV,
    ST_PERIOD,
    ST_RESTART,
    ST_STEP
  } state_e;

endpackage

`default_nettype wire

@@ rtl/core/ttsc_div.sv @@
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module ttsc_div
  import ttsc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic [DIV_W-1:0]  dvd_q, dvd_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DVS_W:0]    shifted;
  logic [DVS_W:0]    trial;
  logic              fits;

  // dividend arrives left aligned, so once iters quotient bits have shifted in the quotient sits in dvd_q
  assign shifted = {rem_q, dvd_q[DIV_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign fits    = (shifted >= {1'b0, dvs_q});

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = req_i.iters;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DIV_W-2:0], fits};
      rem_d = fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == ITER_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;

endmodule

`default_nettype wire

@@ rtl/core/tap_tempo_step_clock.sv @@
// top level of the tap tempo step clock: sequencer, tempo and step state, output register
`default_nettype none

// Tap tempo step clock. Each input item carries a millisecond timestamp, a tap
// flag and a restart flag; each item yields exactly one result item with the
// step, the quarter of the sequence, the tempo and whether the step advanced.
// An ordinary item passes from its acceptance through a tap check (for a tap
// while ext_sync is off), an optional restart and a step check. The item that
// completes a tap series also passes through the summing and division states:
// the stored intervals are summed one per cycle, then the one shared bit-serial
// divider computes 60000/average and the Q16 step period, one quotient bit per
// cycle, and hands each quotient back through a registered done flag. Writing
// initial_bpm starts the same period division, and no item is accepted until it
// ends. A finished result waits in an output register while the next item is
// taken; the step check of that next item stalls while the register is full and
// out_ready_i is low.
module tap_tempo_step_clock_core
  import ttsc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_item_t             in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_item_t                 out_item_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [15:0]          cfg_data_i
);

  state_e state_q, state_d;

  // configuration
  logic        ext_sync_q, ext_sync_d;
  logic [15:0] timeout_q, timeout_d;

  // clock state
  logic [STEP_W-1:0] step_q, step_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [1:0]        bar_q, bar_d;
  logic [31:0]       nst_q, nst_d;
  logic [15:0]       nsf_q, nsf_d;
  logic [31:0]       last_tap_q, last_tap_d;
  logic [TC_W-1:0]   tap_cnt_q, tap_cnt_d;
  logic [15:0]       tempo_q, tempo_d;
  logic [19:0]       pwhole_q, pwhole_d;
  logic [15:0]       pfrac_q, pfrac_d;
  logic              per_item_q, per_item_d;
  logic              out_valid_q, out_valid_d;

  // payload
  logic [15:0]       ivl_q [TAPS_TO_AVERAGE];
  logic              ivl_we;
  logic [IDX_W-1:0]  ivl_idx;
  logic [15:0]       ivl_val;
  logic [31:0]       now_q, now_d;
  logic              restart_q, restart_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [IDX_W-1:0]  sum_idx_q, sum_idx_d;
  logic [15:0]       avg_q, avg_d;
  out_item_t         out_q, out_d;

  logic [31:0]       tap_gap;
  logic              tap_break;
  logic [31:0]       step_gap;
  logic [16:0]       frac_acc;
  logic              out_free;
  logic              cfg_bpm_wr;
  logic [9:0]        cfg_bpm;
  logic [TC_W-1:0]   tap_cnt_inc;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  ttsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // signed gaps so compares survive the wrap of the ms counter
  assign tap_gap     = now_q - last_tap_q;
  assign tap_break   = tap_gap[31] || (tap_gap > {16'b0, timeout_q});
  assign step_gap    = now_q - nst_q;
  assign frac_acc    = {1'b0, nsf_q} + {1'b0, pfrac_q};
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_bpm_wr  = cfg_we_i && (cfg_idx_i == CFG_INITIAL_BPM);
  assign cfg_bpm     = (cfg_data_i[9:0] == 10'd0) ? 10'd1 : cfg_data_i[9:0];
  assign tap_cnt_inc = tap_cnt_q + 1'b1;

  assign in_ready_o = (state_q == ST_IDLE) && !cfg_bpm_wr;

  always_comb begin
    state_d     = state_q;
    ext_sync_d  = ext_sync_q;
    timeout_d   = timeout_q;
    step_d      = step_q;
    pos_d       = pos_q;
    bar_d       = bar_q;
    nst_d       = nst_q;
    nsf_d       = nsf_q;
    last_tap_d  = last_tap_q;
    tap_cnt_d   = tap_cnt_q;
    tempo_d     = tempo_q;
    pwhole_d    = pwhole_q;
    pfrac_d     = pfrac_q;
    per_item_d  = per_item_q;
    out_valid_d = out_valid_q && !out_ready_i;
    now_d       = now_q;
    restart_d   = restart_q;
    sum_d       = sum_q;
    sum_idx_d   = sum_idx_q;
    avg_d       = avg_q;
    out_d       = out_q;
    ivl_we      = 1'b0;
    ivl_idx     = tap_cnt_q[IDX_W-1:0];
    ivl_val     = tap_gap[15:0];
    div_req     = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          now_d     = in_item_i.now_ms;
          restart_d = in_item_i.restart;
          if (in_item_i.tap && !ext_sync_q) begin
            state_d = ST_TAP;
          end else if (in_item_i.restart) begin
            state_d = ST_RESTART;
          end else begin
            state_d = ST_STEP;
          end
        end
      end

      ST_TAP: begin
        last_tap_d = now_q;
        state_d    = restart_q ? ST_RESTART : ST_STEP;
        if (tap_break) begin
          tap_cnt_d = '0;
        end else begin
          ivl_we = 1'b1;
          if (tap_cnt_inc == TC_W'(TAPS_TO_AVERAGE)) begin
            // series complete
            tap_cnt_d = '0;
            sum_d     = '0;
            sum_idx_d = '0;
            state_d   = ST_SUM;
          end else begin
            tap_cnt_d = tap_cnt_inc;
          end
        end
      end

      ST_SUM: begin
        sum_d     = sum_q + SUM_W'(ivl_q[sum_idx_q]);
        sum_idx_d = sum_idx_q + 1'b1;
        if (sum_idx_q == IDX_W'(TAPS_TO_AVERAGE - 1)) begin
          if (TAPS_POW2) begin
            avg_d   = 16'(sum_d >> IDX_W);
            state_d = ST_BPM;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(sum_d) << (DIV_W - SUM_W);
            div_req.divisor  = DVS_W'(TAPS_TO_AVERAGE);
            div_req.iters    = ITER_W'(SUM_W);
            state_d          = ST_AVG_DIV;
          end
        end
      end

      ST_AVG_DIV: begin
        if (div_rsp.done) begin
          avg_d   = div_rsp.quot[15:0];
          state_d = ST_BPM;
        end
      end

      ST_BPM: begin
        if (avg_q == 16'd0) begin
          state_d = restart_q ? ST_RESTART : ST_STEP;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(BPM_NUM) << (DIV_W - 16);
          div_req.divisor  = avg_q;
          div_req.iters    = ITER_W'(16);
          state_d          = ST_BPM_DIV;
        end
      end

      ST_BPM_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quot[15:0] == 16'd0) begin
            // average above 60000 ms gives no tempo
            state_d = restart_q ? ST_RESTART : ST_STEP;
          end else begin
            tempo_d          = div_rsp.quot[15:0];
            div_req.start    = 1'b1;
            div_req.dividend = PER_NUM;
            div_req.divisor  = div_rsp.quot[15:0];
            div_req.iters    = ITER_W'(DIV_W);
            per_item_d       = 1'b1;
            state_d          = ST_PERIOD;
          end
        end
      end

      ST_PERIOD: begin
        if (div_rsp.done) begin
          pwhole_d = div_rsp.quot[35:16];
          pfrac_d  = div_rsp.quot[15:0];
          if (per_item_q) begin
            state_d = restart_q ? ST_RESTART : ST_STEP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_RESTART: begin
        step_d  = '0;
        pos_d   = '0;
        bar_d   = '0;
        nst_d   = now_q + 32'(pwhole_q);
        state_d = ST_STEP;
      end

      ST_STEP: begin
        if (out_free) begin
          if (!step_gap[31]) begin
            nsf_d = frac_acc[15:0];
            nst_d = nst_q + 32'(pwhole_q) + 32'(frac_acc[16]);
            if (step_q == STEP_W'(STEPS_PER_BAR - 1)) begin
              step_d = '0;
              pos_d  = '0;
              bar_d  = '0;
            end else begin
              step_d = step_q + 1'b1;
              if (pos_q == POS_W'(BAR_LEN - 1)) begin
                pos_d = '0;
                bar_d = bar_q + 1'b1;
              end else begin
                pos_d = pos_q + 1'b1;
              end
            end
          end
          out_d.step_index    = 4'(step_d);
          out_d.bar_index     = bar_d;
          out_d.tempo_bpm     = tempo_q;
          out_d.step_advanced = !step_gap[31];
          out_valid_d         = 1'b1;
          state_d             = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // the user must make configuration writes only while no item is in flight; the block does not enforce this
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EXT_SYNC: begin
          ext_sync_d = cfg_data_i[0];
        end
        CFG_INITIAL_BPM: begin
          tempo_d          = 16'(cfg_bpm);
          div_req.start    = 1'b1;
          div_req.dividend = PER_NUM;
          div_req.divisor  = DVS_W'(cfg_bpm);
          div_req.iters    = ITER_W'(DIV_W);
          per_item_d       = 1'b0;
          state_d          = ST_PERIOD;
        end
        CFG_TAP_TIMEOUT: begin
          timeout_d = cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ext_sync_q  <= 1'b0;
      timeout_q   <= 16'd2000;
      step_q      <= '0;
      pos_q       <= '0;
      bar_q       <= '0;
      nst_q       <= '0;
      nsf_q       <= '0;
      last_tap_q  <= '0;
      tap_cnt_q   <= '0;
      tempo_q     <= 16'(RESET_BPM);
      pwhole_q    <= RESET_Q[35:16];
      pfrac_q     <= RESET_Q[15:0];
      per_item_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ext_sync_q  <= ext_sync_d;
      timeout_q   <= timeout_d;
      step_q      <= step_d;
      pos_q       <= pos_d;
      bar_q       <= bar_d;
      nst_q       <= nst_d;
      nsf_q       <= nsf_d;
      last_tap_q  <= last_tap_d;
      tap_cnt_q   <= tap_cnt_d;
      tempo_q     <= tempo_d;
      pwhole_q    <= pwhole_d;
      pfrac_q     <= pfrac_d;
      per_item_q  <= per_item_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    restart_q <= restart_d;
    sum_q     <= sum_d;
    sum_idx_q <= sum_idx_d;
    avg_q     <= avg_d;
    out_q     <= out_d;
    if (ivl_we) begin
      ivl_q[ivl_idx] <= ivl_val;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire
